@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define FFIA_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("allocator assertion failed");

// Implication into the following cycle.
`define FFIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

@@ rtl/core/ffia_pkg.sv @@
// Shared types and constants of the first-fit interval allocator.
`default_nettype none
package ffia_pkg;
  localparam int MAX_INTERVALS_DEF = 32;
  localparam int ADDR_BITS_DEF     = 16;
  localparam longint TOTAL_SIZE_RESET = 65536;

  typedef enum logic [1:0] {
    ST_ALLOC_OK   = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_RELEASED   = 2'd2,
    ST_DROPPED    = 2'd3
  } ffia_status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ALLOC,
    OP_ABSORB,
    OP_INSERT,
    OP_INIT
  } ffia_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_ABSORB,
    S_INSERT,
    S_DONE
  } ffia_state_t;

  // Flags rippling from cell to cell in address order.
  typedef struct packed {
    logic hit_before;
    logic shift;
  } ffia_chain_t;
endpackage
`default_nettype wire

@@ rtl/core/ffia_ifs.sv @@
// Channel interfaces of the first-fit interval allocator.
`default_nettype none
interface ffia_req_if #(parameter int ADDR_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [ADDR_BITS-1:0] block_start;
  logic [ADDR_BITS:0]   block_size;
  modport source (output valid, mode, block_start, block_size, input ready);
  modport sink   (input valid, mode, block_start, block_size, output ready);
endinterface

interface ffia_rsp_if #(parameter int ADDR_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

interface ffia_cfg_if #(parameter int ADDR_BITS = 16);
  logic               valid;
  logic               ready;
  logic [ADDR_BITS:0] total_size;
  modport source (output valid, total_size, input ready);
  modport sink   (input valid, total_size, output ready);
endinterface
`default_nettype wire

@@ rtl/core/first_fit_interval_allocator_unit.sv @@
// Top level of the first-fit interval allocator.
// The block keeps the free intervals of an address range, sorted by address,
// in a row of cells, one interval per cell. Requests arrive on the req
// channel: mode 0 allocates block_size units from the first interval large
// enough, mode 1 releases a span and merges it with free neighbours. Each
// request gives exactly one transfer on the rsp channel with a status and,
// for a successful allocation, the start address.
// The cfg channel writes total_size, which reinitialises the list to one
// interval (none for a size of zero); it is meant to be written only while no
// request is in flight, and a pending cfg transfer holds off the req channel.
// An allocation goes from its transfer through ALLOC to DONE. A release
// goes through ABSORB, which repeats while a free interval touches the span,
// as the cells fold one neighbouring interval into the span in each cycle,
// then through INSERT to DONE. A release dropped for a full list goes from
// ABSORB to DONE, and an ignored release goes straight to DONE. Requests are
// handled one at a time, so the next request is taken as soon as the previous
// result has been produced. A new request is taken while the previous result
// still waits; if the receiver stalls, the finished result is held until the
// slot frees. Synchronous reset restores a total size of 65536, at most
// 2^ADDR_BITS, with the list holding that one interval.
`default_nettype none
`include "assert_macros.svh"
module first_fit_interval_allocator_unit #(
  parameter int MAX_INTERVALS = ffia_pkg::MAX_INTERVALS_DEF,
  parameter int ADDR_BITS     = ffia_pkg::ADDR_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ffia_req_if.sink   req,
  ffia_rsp_if.source rsp,
  ffia_cfg_if.sink   cfg
);
  import ffia_pkg::*;

  localparam int LW = ADDR_BITS + 1;
  localparam logic [LW-1:0] LIMIT = {1'b1, {ADDR_BITS{1'b0}}};
  localparam longint LIMIT_L = longint'(1) << ADDR_BITS;
  localparam logic [LW-1:0] RESET_SIZE =
    (TOTAL_SIZE_RESET > LIMIT_L) ? LIMIT : LW'(TOTAL_SIZE_RESET);

  ffia_state_t state, state_next;
  logic [LW-1:0]        total;
  logic                 mode;
  logic [ADDR_BITS-1:0] span_base;
  logic [LW-1:0]        span_end;
  logic                 absorbed;
  ffia_status_t         res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic                 out_valid;
  ffia_status_t         out_status;
  logic [ADDR_BITS-1:0] out_addr;

  ffia_op_t        op;
  logic [LW-1:0]   key_a, key_b;

  // Cell row.
  logic                 cv [MAX_INTERVALS+1];
  logic [ADDR_BITS-1:0] cb [MAX_INTERVALS+1];
  logic [LW-1:0]        cl [MAX_INTERVALS+1];
  ffia_chain_t          chain [MAX_INTERVALS+1];
  logic [MAX_INTERVALS-1:0] first_vec, valid_vec;

  assign cv[MAX_INTERVALS] = 1'b0;
  assign cb[MAX_INTERVALS] = '0;
  assign cl[MAX_INTERVALS] = '0;
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    logic                 lv;
    logic [ADDR_BITS-1:0] lb;
    logic [LW-1:0]        ll;
    if (i == 0) begin : g_edge
      assign lv = 1'b0;
      assign lb = '0;
      assign ll = '0;
    end else begin : g_inner
      assign lv = cv[i-1];
      assign lb = cb[i-1];
      assign ll = cl[i-1];
    end
    ffia_cell #(
      .ADDR_BITS (ADDR_BITS),
      .FIRST     (i == 0),
      .RESET_LEN ((i == 0) ? RESET_SIZE : '0)
    ) u_cell (
      .clk, .rst, .op, .key_a, .key_b,
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .left_valid  (lv),
      .left_base   (lb),
      .left_len    (ll),
      .right_valid (cv[i+1]),
      .right_base  (cb[i+1]),
      .right_len   (cl[i+1]),
      .valid       (cv[i]),
      .base        (cb[i]),
      .len         (cl[i]),
      .first       (first_vec[i])
    );
    assign valid_vec[i] = cv[i];
  end

  // The hit cell is one-hot, so its interval is gathered by an AND-OR.
  logic                 any_hit;
  logic [ADDR_BITS-1:0] hit_base;
  logic [LW-1:0]        hit_len;
  logic [LW-1:0]        hit_end;
  always_comb begin
    hit_base = '0;
    hit_len  = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      hit_base = hit_base | (first_vec[i] ? cb[i] : '0);
      hit_len  = hit_len  | (first_vec[i] ? cl[i] : '0);
    end
  end
  assign any_hit = chain[MAX_INTERVALS].hit_before;
  assign hit_end = {1'b0, hit_base} + hit_len;

  // Request decode at the transfer.
  logic                 req_xfer, cfg_xfer, out_free;
  logic [LW:0]          raw_end;
  logic [LW-1:0]        clip_end;
  logic                 rel_ignore;
  logic [LW-1:0]        cfg_size;

  // Requested allocation size is held in span_end during an allocation.
  logic [LW-1:0] key_b_size;
  assign key_b_size = span_end;

  // A configuration write takes precedence, so no request transfer shares its edge.
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign raw_end   = {2'b00, req.block_start} + {1'b0, req.block_size};
  assign clip_end  = (raw_end > {1'b0, total}) ? total : raw_end[LW-1:0];
  assign rel_ignore = ({1'b0, req.block_start} >= total) || (req.block_size == '0);
  assign cfg_size  = (cfg.total_size > LIMIT) ? LIMIT : cfg.total_size;

  always_comb begin
    state_next = state;
    op         = OP_HOLD;
    key_a      = '0;
    key_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (cfg_xfer) begin
          op    = OP_INIT;
          key_b = cfg_size;
        end else if (req_xfer) begin
          if (!req.mode) begin
            state_next = S_ALLOC;
          end else if (rel_ignore) begin
            state_next = S_DONE;
          end else begin
            state_next = S_ABSORB;
          end
        end
      end
      S_ALLOC: begin
        op         = OP_ALLOC;
        key_a      = key_b_size;
        state_next = S_DONE;
      end
      S_ABSORB: begin
        op    = OP_ABSORB;
        key_a = {1'b0, span_base};
        key_b = span_end;
        if (!any_hit) begin
          state_next = (!absorbed && valid_vec[MAX_INTERVALS-1]) ? S_DONE : S_INSERT;
        end
      end
      S_INSERT: begin
        op         = OP_INSERT;
        key_a      = {1'b0, span_base};
        key_b      = span_end - {1'b0, span_base};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= RESET_SIZE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_xfer) begin
        total <= cfg_size;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_xfer) begin
      mode       <= req.mode;
      absorbed   <= 1'b0;
      span_base  <= req.block_start;
      span_end   <= req.mode ? clip_end : req.block_size;
      res_status <= ST_RELEASED;
      res_addr   <= '0;
    end
    unique case (state)
      S_ALLOC: begin
        res_status <= any_hit ? ST_ALLOC_OK : ST_ALLOC_FAIL;
        res_addr   <= any_hit ? hit_base : '0;
      end
      S_ABSORB: begin
        if (any_hit) begin
          absorbed  <= 1'b1;
          span_base <= (hit_base < span_base) ? hit_base : span_base;
          span_end  <= (hit_end > span_end) ? hit_end : span_end;
        end else if (!absorbed && valid_vec[MAX_INTERVALS-1]) begin
          res_status <= ST_DROPPED;
        end
      end
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.address = out_addr;

  // Valid cells always form an unbroken run from the first cell.
  `FFIA_ASSERT_ALWAYS(a_valid_run, clk, rst,
    ((valid_vec + MAX_INTERVALS'(1)) & valid_vec) == '0)
  // Each absorbed interval leaves the row one entry shorter.
  `FFIA_ASSERT_NEXT(a_absorb_shrinks, clk, rst, (state == S_ABSORB) && any_hit,
    $countones(valid_vec) == $countones($past(valid_vec)) - 1)
  // An allocation always goes from ALLOC straight to DONE.
  `FFIA_ASSERT_NEXT(a_alloc_one_cycle, clk, rst, state == S_ALLOC && !mode,
    state == S_DONE)
endmodule
`default_nettype wire

@@ rtl/core/ffia_cell.sv @@
// One free-interval cell of the allocator chain.
`default_nettype none
module ffia_cell #(
  parameter int ADDR_BITS = 16,
  parameter bit FIRST     = 1'b0,
  parameter logic [ADDR_BITS:0] RESET_LEN = '0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ffia_pkg::ffia_op_t       op,
  input  wire logic [ADDR_BITS:0]       key_a,
  input  wire logic [ADDR_BITS:0]       key_b,
  input  wire ffia_pkg::ffia_chain_t    chain_in,
  output ffia_pkg::ffia_chain_t         chain_out,
  input  wire logic                     left_valid,
  input  wire logic [ADDR_BITS-1:0]     left_base,
  input  wire logic [ADDR_BITS:0]       left_len,
  input  wire logic                     right_valid,
  input  wire logic [ADDR_BITS-1:0]     right_base,
  input  wire logic [ADDR_BITS:0]       right_len,
  output logic                          valid,
  output logic [ADDR_BITS-1:0]          base,
  output logic [ADDR_BITS:0]            len,
  output logic                          first
);
  import ffia_pkg::*;

  logic                 hit;
  logic                 take;
  logic [ADDR_BITS:0]   end_addr;
  logic                 valid_next;
  logic [ADDR_BITS-1:0] base_next;
  logic [ADDR_BITS:0]   len_next;

  assign end_addr = {1'b0, base} + len;

  always_comb begin
    unique case (op)
      OP_ALLOC:  hit = valid && (len >= key_a);
      OP_ABSORB: hit = valid && (end_addr >= key_a) && ({1'b0, base} <= key_b);
      OP_INSERT: hit = !valid || ({1'b0, base} > key_a);
      default:   hit = 1'b0;
    endcase
    unique case (op)
      OP_ALLOC:             take = (len == key_a);
      OP_ABSORB, OP_INSERT: take = 1'b1;
      default:              take = 1'b0;
    endcase
  end

  assign first                = hit && !chain_in.hit_before;
  assign chain_out.hit_before = chain_in.hit_before || hit;
  assign chain_out.shift      = chain_in.shift || (first && take);

  always_comb begin
    valid_next = valid;
    base_next  = base;
    len_next   = len;
    unique case (op)
      OP_ALLOC, OP_ABSORB: begin
        if (chain_out.shift) begin
          valid_next = right_valid;
          base_next  = right_base;
          len_next   = right_len;
        end else if (first) begin
          base_next = base + key_a[ADDR_BITS-1:0];
          len_next  = len - key_a;
        end
      end
      OP_INSERT: begin
        if (first) begin
          valid_next = 1'b1;
          base_next  = key_a[ADDR_BITS-1:0];
          len_next   = key_b;
        end else if (chain_in.shift) begin
          valid_next = left_valid;
          base_next  = left_base;
          len_next   = left_len;
        end
      end
      OP_INIT: begin
        valid_next = FIRST && (key_b != '0);
        base_next  = '0;
        len_next   = FIRST ? key_b : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= FIRST;
      base  <= '0;
      len   <= FIRST ? RESET_LEN : '0;
    end else begin
      valid <= valid_next;
      base  <= base_next;
      len   <= len_next;
    end
  end
endmodule
`default_nettype wire
